FILE: src/fls_pkg.sv
`default_nettype none
package fls_pkg;

    localparam int CW    = 32;                 // coordinate width
    localparam int FRAC  = 16;                 // coordinate fraction bits
    localparam int TF    = 30;                 // fraction bits of the parameter t
    localparam int AW    = 31;                 // aspect ratio width
    localparam int NPL   = 5;                  // planes per segment
    localparam int DW    = CW + 1;             // coordinate difference width
    localparam int LW    = AW + 1 + CW - FRAC; // scaled side limit width
    localparam int PW    = LW + 3;             // plane numerator and denominator width
    localparam int RW    = PW + 1;             // divider remainder width
    localparam int QB    = TF + 1;             // quotient bits below saturation
    localparam int TW    = TF + 3;             // signed t width, holds +-2.0
    localparam int QD    = 8;                  // queue depth, a power of two
    localparam int QAW   = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);
    localparam int ONE   = 1 << FRAC;
    localparam int T_ONE = 1 << TF;

    localparam logic [1:0] MODE_UNIT    = 2'd0;
    localparam logic [1:0] MODE_ASP_X   = 2'd1;
    localparam logic [1:0] MODE_ASP_Y   = 2'd2;
    localparam logic [1:0] MODE_NEARFAR = 2'd3;

    typedef enum logic [1:0] {
        K_IGNORE,
        K_REJECT,
        K_ENTER,
        K_LEAVE
    } t_kind;

    // Element 0 is start_x, then start_y, start_z, end_x, end_y, end_z.
    typedef logic [5:0][CW-1:0] t_seg;

    typedef struct packed {
        logic signed [PW-1:0] den;
        logic signed [PW-1:0] num;
    } t_plane;

    typedef struct packed {
        t_plane [NPL-1:0] pl;
        t_seg             seg;
    } t_qent;

    typedef struct packed {
        logic [1:0]           mode;
        logic [AW-1:0]        aspect;
        logic signed [31:0]   near_z;
        logic signed [31:0]   far_z;
    } t_cfg;

endpackage
`default_nettype wire

FILE: src/fls_front.sv
`default_nettype none
module fls_front import fls_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tvalid,
    input  wire logic [6*CW-1:0]  i_tdata,
    output logic                  o_tready,
    input  wire t_cfg             i_cfg,
    input  wire logic [QCW-1:0]   i_q_count,
    output logic                  o_push,
    output t_qent                 o_ent
);

    logic               r_a_vld, r_b_vld;
    t_seg               r_a_seg, r_b_seg;
    logic signed [LW-1:0] r_b_l1, r_b_l2;
    logic signed [AW+CW:0] w_m1, w_m2;
    logic [QCW:0]       w_inflight;

    // Items in the two front stages already hold a queue slot.
    assign w_inflight = {1'b0, i_q_count} + (QCW+1)'(r_a_vld) + (QCW+1)'(r_b_vld);
    assign o_tready   = w_inflight < (QCW+1)'(QD);

    assign w_m1 = $signed({1'b0, i_cfg.aspect}) * $signed(r_a_seg[2]);
    assign w_m2 = $signed({1'b0, i_cfg.aspect}) * $signed(r_a_seg[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_tvalid && o_tready;
            r_b_vld <= r_a_vld;
        end
        r_a_seg <= t_seg'(i_tdata);
        r_b_seg <= r_a_seg;
        r_b_l1  <= w_m1[FRAC +: LW];
        r_b_l2  <= w_m2[FRAC +: LW];
    end

    always_comb begin
        logic signed [PW-1:0] x1, y1, z1, x2, y2, z2, lz1, lz2;
        logic signed [PW-1:0] lx1, lx2, ly1, ly2;
        x1  = PW'($signed(r_b_seg[0]));
        y1  = PW'($signed(r_b_seg[1]));
        z1  = PW'($signed(r_b_seg[2]));
        x2  = PW'($signed(r_b_seg[3]));
        y2  = PW'($signed(r_b_seg[4]));
        z2  = PW'($signed(r_b_seg[5]));
        lz1 = PW'(r_b_l1);
        lz2 = PW'(r_b_l2);
        ly1 = (i_cfg.mode == MODE_ASP_Y) ? lz1 : z1;
        ly2 = (i_cfg.mode == MODE_ASP_Y) ? lz2 : z2;
        lx1 = (i_cfg.mode == MODE_ASP_X) ? lz1 : z1;
        lx2 = (i_cfg.mode == MODE_ASP_X) ? lz2 : z2;
        o_ent.seg = r_b_seg;
        if (i_cfg.mode == MODE_NEARFAR) begin
            o_ent.pl[0].den = z2 - z1;
            o_ent.pl[0].num = PW'(i_cfg.near_z) - z1;
            o_ent.pl[1].den = z1 - z2;
            o_ent.pl[1].num = z1 - PW'(i_cfg.far_z);
            for (int i = 2; i < NPL; i++) begin
                o_ent.pl[i].den = '0;
                o_ent.pl[i].num = '0;
            end
        end else begin
            o_ent.pl[0].den = z2 - z1;
            o_ent.pl[0].num = PW'(ONE) - z1;
            o_ent.pl[1].den = (ly2 - y2) - (ly1 - y1);
            o_ent.pl[1].num = y1 - ly1;
            o_ent.pl[2].den = (ly2 + y2) - (ly1 + y1);
            o_ent.pl[2].num = -(ly1 + y1);
            o_ent.pl[3].den = (lx2 - x2) - (lx1 - x1);
            o_ent.pl[3].num = x1 - lx1;
            o_ent.pl[4].den = (lx2 + x2) - (lx1 + x1);
            o_ent.pl[4].num = -(lx1 + x1);
        end
    end

    assign o_push = r_b_vld;

endmodule
`default_nettype wire

FILE: src/fls_queue.sv
`default_nettype none
module fls_queue import fls_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire t_qent          i_ent,
    input  wire logic           i_pop,
    output t_qent               o_ent,
    output logic [QCW-1:0]      o_count
);

    t_qent          r_mem [0:QD-1];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_ent;
    end

    assign o_ent   = r_mem[r_rp];
    assign o_count = r_count;

endmodule
`default_nettype wire

FILE: src/fls_div.sv
`default_nettype none
module fls_div import fls_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_plane             i_pl,
    output logic signed [TW-1:0]    o_t,
    output t_kind                   o_kind
);

    logic [PW-1:0] w_nmag, w_dmag;
    t_kind         w_kind;
    logic [RW-1:0] r_r [0:QB];
    logic [PW-1:0] r_d [0:QB];
    logic [QB-1:0] r_q [0:QB];
    t_kind         r_kind [0:QB];
    logic [QB:0]   r_neg, r_sat;
    logic [RW-1:0] w_sh [0:QB-1];
    logic [RW-1:0] w_rn [0:QB-1];
    logic [QB-1:0] w_ge;
    logic [QB:0]   w_mag;

    assign w_nmag = i_pl.num[PW-1] ? -i_pl.num : i_pl.num;
    assign w_dmag = i_pl.den[PW-1] ? -i_pl.den : i_pl.den;

    always_comb begin
        priority if (i_pl.den[PW-1])                    w_kind = K_LEAVE;
        else if (i_pl.den != '0)                        w_kind = K_ENTER;
        else if (!i_pl.num[PW-1] && i_pl.num != '0)     w_kind = K_REJECT;
        else                                            w_kind = K_IGNORE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= RW'(w_nmag);
            r_d[0]    <= w_dmag;
            r_q[0]    <= '0;
            r_neg[0]  <= i_pl.num[PW-1] ^ i_pl.den[PW-1];
            r_sat[0]  <= {1'b0, w_nmag} >= {w_dmag, 1'b0};
            r_kind[0] <= w_kind;
        end
    end

    // One quotient bit per stage, most significant first. The first step
    // takes the integer bit without a shift.
    for (genvar k = 0; k < QB; k++) begin : g_step
        always_comb begin
            w_sh[k] = (k == 0) ? r_r[k] : {r_r[k][RW-2:0], 1'b0};
            w_ge[k] = w_sh[k] >= {1'b0, r_d[k]};
            w_rn[k] = w_ge[k] ? w_sh[k] - {1'b0, r_d[k]} : w_sh[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k+1]    <= w_rn[k];
                r_d[k+1]    <= r_d[k];
                r_q[k+1]    <= {r_q[k][QB-2:0], w_ge[k]};
                r_neg[k+1]  <= r_neg[k];
                r_sat[k+1]  <= r_sat[k];
                r_kind[k+1] <= r_kind[k];
            end
        end
    end

    assign w_mag  = r_sat[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, r_q[QB]};
    assign o_t    = r_neg[QB] ? -TW'(w_mag) : TW'(w_mag);
    assign o_kind = r_kind[QB];

endmodule
`default_nettype wire

FILE: src/fls_back.sv
`default_nettype none
module fls_back import fls_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_qent             i_ent,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [6*CW-1:0]        o_tdata,
    output logic                   o_tuser
);

    logic                   w_en;
    logic [QB:0]            r_vld;
    t_seg                   r_seg [0:QB];
    logic signed [TW-1:0]   w_t [0:NPL-1];
    t_kind                  w_kind [0:NPL-1];

    logic                   n_ok;
    logic signed [TW-1:0]   n_te, n_tl;
    logic signed [DW-1:0]   n_d [0:2];

    logic                   r_ev_vld, r_ev_ok;
    logic signed [TW-1:0]   r_ev_te, r_ev_tl;
    t_seg                   r_ev_seg;
    logic signed [DW-1:0]   r_ev_d [0:2];

    logic signed [DW+TF+1:0] w_pe [0:2];
    logic signed [DW+TF+1:0] w_ps [0:2];

    logic                   r_mu_vld, r_mu_ok, r_mu_mve, r_mu_mvs;
    t_seg                   r_mu_seg;
    logic [CW-1:0]          r_mu_pe [0:2];
    logic [CW-1:0]          r_mu_ps [0:2];

    logic                   r_o_vld, r_o_acc;
    t_seg                   r_o_seg;
    t_seg                   n_o_seg;

    // The whole back pipeline moves together; the output register is its end.
    assign w_en  = !r_o_vld || i_tready;
    assign o_pop = w_en && !i_empty;

    for (genvar i = 0; i < NPL; i++) begin : g_div
        fls_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_pl   (i_ent.pl[i]),
            .o_t    (w_t[i]),
            .o_kind (w_kind[i])
        );
    end

    // Planes are applied in order; each may reject or tighten the interval.
    always_comb begin
        n_ok = 1'b1;
        n_te = '0;
        n_tl = TW'(T_ONE);
        for (int i = 0; i < NPL; i++) begin
            if (n_ok) begin
                unique case (w_kind[i])
                    K_ENTER: begin
                        if (w_t[i] > n_tl)      n_ok = 1'b0;
                        else if (w_t[i] > n_te) n_te = w_t[i];
                    end
                    K_LEAVE: begin
                        if (w_t[i] < n_te)      n_ok = 1'b0;
                        else if (w_t[i] < n_tl) n_tl = w_t[i];
                    end
                    K_REJECT: n_ok = 1'b0;
                    K_IGNORE: ;
                endcase
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_d[i] = DW'($signed(r_seg[QB][i+3])) - DW'($signed(r_seg[QB][i]));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pe[i] = r_ev_d[i] * $signed({1'b0, r_ev_tl[TF:0]});
            w_ps[i] = r_ev_d[i] * $signed({1'b0, r_ev_te[TF:0]});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_o_seg[i]   = r_mu_mvs ? r_mu_seg[i] + r_mu_ps[i] : r_mu_seg[i];
            n_o_seg[i+3] = r_mu_mve ? r_mu_seg[i] + r_mu_pe[i] : r_mu_seg[i+3];
        end
        if (!r_mu_ok) n_o_seg = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ev_vld <= 1'b0;
            r_mu_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_vld    <= {r_vld[QB-1:0], !i_empty};
            r_ev_vld <= r_vld[QB];
            r_mu_vld <= r_ev_vld;
            r_o_vld  <= r_mu_vld;
        end
        if (w_en) begin
            r_seg[0] <= i_ent.seg;
            for (int j = 0; j < QB; j++) r_seg[j+1] <= r_seg[j];
            r_ev_ok  <= n_ok;
            r_ev_te  <= n_te;
            r_ev_tl  <= n_tl;
            r_ev_seg <= r_seg[QB];
            for (int i = 0; i < 3; i++) begin
                r_ev_d[i]  <= n_d[i];
                r_mu_pe[i] <= w_pe[i][TF +: CW];
                r_mu_ps[i] <= w_ps[i][TF +: CW];
            end
            r_mu_ok  <= r_ev_ok;
            r_mu_mve <= r_ev_tl < TW'(T_ONE);
            r_mu_mvs <= !r_ev_te[TW-1] && (r_ev_te != '0);
            r_mu_seg <= r_ev_seg;
            r_o_acc  <= r_mu_ok;
            r_o_seg  <= n_o_seg;
        end
    end

    assign o_tvalid = r_o_vld;
    assign o_tuser  = r_o_acc;
    assign o_tdata  = r_o_seg;

endmodule
`default_nettype wire

FILE: src/frustum_line_segment_clipper_top.sv
// Each accepted input beat gives one result beat, with t in Q2.30 from the
// 31-stage division pipeline that runs one t bit per stage.
// Throughput: one segment per cycle when not stalled; a queue of 8 entries parts the
// front stages from the back pipeline, which stalls as a whole on m_axis_tready.
// Reset: synchronous, active low; clears the pipeline valids and the queue and
// loads the configuration registers with their defaults.
`default_nettype none
module frustum_line_segment_clipper_top import fls_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [6*CW-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_start_z,
    // clipped_end_x, clipped_end_y, clipped_end_z
    output logic [6*CW-1:0]        m_axis_tdata,
    // accepted
    output logic                   m_axis_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ASPECT = 2'd1;
    localparam logic [1:0] REG_NEAR   = 2'd2;
    localparam logic [1:0] REG_FAR    = 2'd3;

    t_cfg           r_cfg;
    logic           w_push, w_pop, w_q_empty;
    t_qent          w_push_ent, w_pop_ent;
    logic [QCW-1:0] w_q_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_UNIT;
            r_cfg.aspect <= AW'(65536);
            r_cfg.near_z <= 32'sd65536;
            r_cfg.far_z  <= 32'sd65536000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MODE:   r_cfg.mode   <= pwdata[1:0];
                REG_ASPECT: r_cfg.aspect <= pwdata[AW-1:0];
                REG_NEAR:   r_cfg.near_z <= pwdata;
                REG_FAR:    r_cfg.far_z  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {30'b0, r_cfg.mode};
            REG_ASPECT: prdata = {1'b0, r_cfg.aspect};
            REG_NEAR:   prdata = r_cfg.near_z;
            REG_FAR:    prdata = r_cfg.far_z;
        endcase
    end

    fls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .o_tready  (s_axis_tready),
        .i_cfg     (r_cfg),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_ent     (w_push_ent)
    );

    fls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .i_pop   (w_pop),
        .o_ent   (w_pop_ent),
        .o_count (w_q_count)
    );

    assign w_q_empty = (w_q_count == '0);

    fls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ent    (w_pop_ent),
        .i_empty  (w_q_empty),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected segment carries nonzero coordinates");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> w_q_count < QCW'(QD))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_count != '0)
        else $error("queue read while empty");

endmodule
`default_nettype wire

FILE: dv/clip_checker.sv
module clip_checker import fls_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    input  wire logic            s_axis_tready,
    input  wire logic [6*CW-1:0] s_axis_tdata,
    input  wire logic            m_axis_tvalid,
    input  wire logic            m_axis_tready,
    input  wire logic [6*CW-1:0] m_axis_tdata,
    input  wire logic            m_axis_tuser,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic            pready,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output int                   o_errors,
    output int                   o_pending
);

    localparam logic [3:0] ADDR_MODE   = 4'd0;
    localparam logic [3:0] ADDR_ASPECT = 4'd4;
    localparam logic [3:0] ADDR_NEAR   = 4'd8;
    localparam logic [3:0] ADDR_FAR    = 4'd12;
    localparam longint T_UNIT = 64'sd1 << TF;

    typedef struct {
        logic            acc;
        logic [6*CW-1:0] pts;
    } t_clip_res;

    logic [1:0]         mode_q;
    logic [30:0]        aspect_q;
    logic signed [31:0] near_q;
    logic signed [31:0] far_q;
    t_clip_res          expected_q[$];

    assign o_pending = expected_q.size();

    // floor(v * a / 2^sh) with the magnitude capped at 2^58.
    function automatic longint scale_floor(longint v, longint unsigned a, int sh);
        longint unsigned m, hi, lo, q, rem;
        m  = v < 0 ? -v : v;
        hi = a * (m >> 32);
        lo = a * (m & 64'hFFFF_FFFF);
        if ((hi >> (26 + sh)) != 0) begin
            q = 64'd1 << 58;
            rem = 0;
        end else begin
            q = (hi << (32 - sh)) + (lo >> sh);
            if (q > (64'd1 << 58)) q = 64'd1 << 58;
            rem = lo & ((64'd1 << sh) - 1);
        end
        if (v < 0) return -longint'(q + (rem != 0));
        return longint'(q);
    endfunction

    function automatic longint t_ratio(longint num, longint den);
        longint unsigned n, d, q, r;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n >= 2 * d) q = 64'd1 << (TF + 1);
        else begin
            q = n / d;
            r = n % d;
            for (int i = 0; i < TF; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit bound_plane(longint den, longint num,
                                       inout longint t_in, inout longint t_out);
        longint t;
        if (den > 0) begin
            t = t_ratio(num, den);
            if (t > t_out) return 0;
            if (t > t_in) t_in = t;
        end else if (den < 0) begin
            t = t_ratio(num, den);
            if (t < t_in) return 0;
            if (t < t_out) t_out = t;
        end else if (num > 0) begin
            return 0;
        end
        return 1;
    endfunction

    function automatic bit side_planes(longint c1, longint c2, longint l1, longint l2,
                                       inout longint t_in, inout longint t_out);
        if (!bound_plane((l2 - c2) - (l1 - c1), c1 - l1, t_in, t_out)) return 0;
        return bound_plane((l2 + c2) - (l1 + c1), -(l1 + c1), t_in, t_out);
    endfunction

    function automatic t_clip_res clip_segment(logic [6*CW-1:0] seg);
        t_clip_res r;
        longint p[6];
        longint d[3];
        longint s[3];
        longint e[3];
        longint t_in, t_out, zy1, zy2, zx1, zx2;
        bit ok;
        t_in = 0;
        t_out = T_UNIT;
        for (int i = 0; i < 6; i++) p[i] = longint'($signed(seg[i*CW +: CW]));
        for (int i = 0; i < 3; i++) d[i] = p[i+3] - p[i];
        if (mode_q == MODE_NEARFAR) begin
            ok = bound_plane(d[2], longint'(near_q) - p[2], t_in, t_out) &&
                 bound_plane(-d[2], p[2] - longint'(far_q), t_in, t_out);
        end else begin
            zy1 = p[2]; zy2 = p[5]; zx1 = p[2]; zx2 = p[5];
            if (mode_q == MODE_ASP_Y) begin
                zy1 = scale_floor(p[2], aspect_q, FRAC);
                zy2 = scale_floor(p[5], aspect_q, FRAC);
            end else if (mode_q == MODE_ASP_X) begin
                zx1 = scale_floor(p[2], aspect_q, FRAC);
                zx2 = scale_floor(p[5], aspect_q, FRAC);
            end
            ok = bound_plane(d[2], longint'(ONE) - p[2], t_in, t_out) &&
                 side_planes(p[1], p[4], zy1, zy2, t_in, t_out) &&
                 side_planes(p[0], p[3], zx1, zx2, t_in, t_out);
        end
        r.acc = ok;
        r.pts = '0;
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                s[i] = p[i];
                e[i] = p[i+3];
            end
            // The end point moves first, from the unmoved start point.
            if (t_out < T_UNIT)
                for (int i = 0; i < 3; i++) e[i] = p[i] + scale_floor(d[i], t_out, TF);
            if (t_in > 0)
                for (int i = 0; i < 3; i++) s[i] = p[i] + scale_floor(d[i], t_in, TF);
            for (int i = 0; i < 3; i++) begin
                r.pts[i*CW +: CW]     = s[i][CW-1:0];
                r.pts[(i+3)*CW +: CW] = e[i][CW-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_clip_res want;
        if (!i_rst_n) begin
            mode_q   <= MODE_UNIT;
            aspect_q <= 31'd65536;
            near_q   <= 32'sd65536;
            far_q    <= 32'sd65536000;
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_MODE:   mode_q   <= pwdata[1:0];
                    ADDR_ASPECT: aspect_q <= pwdata[30:0];
                    ADDR_NEAR:   near_q   <= pwdata;
                    ADDR_FAR:    far_q    <= pwdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(clip_segment(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.acc !== m_axis_tuser || want.pts !== m_axis_tdata) begin
                        o_errors <= o_errors + 1;
                        if (want.acc !== m_axis_tuser)
                            $error("accepted: expected %0d, actual %0d",
                                   want.acc, m_axis_tuser);
                        for (int i = 0; i < 6; i++)
                            if (want.pts[i*CW +: CW] !== m_axis_tdata[i*CW +: CW])
                                $error("clipped_%s_%s: expected %0d, actual %0d",
                                       i < 3 ? "start" : "end",
                                       (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                                       $signed(want.pts[i*CW +: CW]),
                                       $signed(m_axis_tdata[i*CW +: CW]));
                    end
                end
            end
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    import fls_pkg::*;

    localparam logic [3:0] ADDR_MODE   = 4'd0;
    localparam logic [3:0] ADDR_ASPECT = 4'd4;
    localparam logic [3:0] ADDR_NEAR   = 4'd8;
    localparam logic [3:0] ADDR_FAR    = 4'd12;
    localparam int  ONE_Q = 65536;
    localparam longint CYCLE_LIMIT = 400000;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [6*CW-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [6*CW-1:0] m_axis_tdata;
    logic            m_axis_tuser;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [3:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;
    int              errors;
    int              pending;
    longint          cycles;
    bit              calm;

    frustum_line_segment_clipper_top uut (.*);

    clip_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts, none once the run is calm.
    initial begin
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] value);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic send_segment(logic [6*CW-1:0] seg);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= seg;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 | ($urandom_range(0, 3));
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q);
        endcase
    endfunction

    // Mostly segments near the view volume, so clipping actually happens.
    function automatic logic [6*CW-1:0] pick_segment();
        logic [6*CW-1:0] seg;
        logic [31:0] z;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 9) == 0) seg[i*CW +: CW] = pick_coord();
            else if (i % 3 == 2) begin
                z = $urandom_range(0, 6 * ONE_Q);
                seg[i*CW +: CW] = z;
            end else seg[i*CW +: CW] = 32'($signed($urandom_range(0, 12 * ONE_Q)) - 6 * ONE_Q);
        end
        if ($urandom_range(0, 15) == 0) seg[5*CW +: CW] = seg[2*CW +: CW];
        return seg;
    endfunction

    function automatic logic [6*CW-1:0] make_seg(int sx, int sy, int sz, int ex, int ey, int ez);
        return {32'(ez), 32'(ey), 32'(ex), 32'(sz), 32'(sy), 32'(sx)};
    endfunction

    initial begin
        logic [31:0] aspects[4];
        logic [31:0] nears[4];
        logic [31:0] fars[4];
        calm = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed segments in the default unit frustum.
        send_segment(make_seg(0, 0, 2 * ONE_Q, 0, 0, 3 * ONE_Q));
        send_segment(make_seg(0, 0, 0, 0, 0, 4 * ONE_Q));
        send_segment(make_seg(-5 * ONE_Q, 0, 2 * ONE_Q, 5 * ONE_Q, 0, 2 * ONE_Q));
        send_segment(make_seg(0, -5 * ONE_Q, 2 * ONE_Q, 0, 5 * ONE_Q, 3 * ONE_Q));
        send_segment(make_seg(0, 0, ONE_Q / 2, 0, 0, ONE_Q / 2));
        send_segment(make_seg(9 * ONE_Q, 0, 2 * ONE_Q, 9 * ONE_Q, 0, 3 * ONE_Q));
        send_segment(make_seg(3 * ONE_Q, 0, 2 * ONE_Q, 0, 3 * ONE_Q, 2 * ONE_Q));
        send_segment({6{32'h8000_0000}});
        send_segment({6{32'h7FFF_FFFF}});
        send_segment({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
        send_segment({3{32'hFFFF_FFFF, 32'h0}});
        drain_results();

        aspects = '{32'd0, 32'h7FFF_FFFF, 32'd32768, 32'd131072};
        nears   = '{32'h8000_0000, 32'd0, 32'd65536, 32'h7FFF_FFFF};
        fars    = '{32'h7FFF_FFFF, 32'd65536, 32'd262144, 32'h8000_0000};
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(ADDR_MODE, 32'(ph % 4) | ($urandom & 32'hFFFF_FFFC));
            reg_write(ADDR_ASPECT, ph < 4 ? aspects[ph] : ($urandom_range(0, 3) == 0
                      ? $urandom : $urandom_range(0, 4 * ONE_Q)));
            reg_write(ADDR_NEAR, ph < 4 ? nears[ph] : $urandom_range(0, 2 * ONE_Q));
            reg_write(ADDR_FAR, ph < 4 ? fars[ph] : $urandom_range(ONE_Q, 6 * ONE_Q));
            if (ph == 3) begin
                send_segment(make_seg(0, 0, -ONE_Q, 0, 0, ONE_Q));
                send_segment(make_seg(1, 2, 3, 4, 5, 3));
            end
            if (ph == 11) calm = 1;
            for (int k = 0; k < 50; k++) send_segment(pick_segment());
            drain_results();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
